FILE: hw/rtl/bitmap_page_frame_allocator_macros.svh
// Assertion helpers for the checker
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define BPFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bpfa_pkg.sv
`default_nettype none
package bpfa_pkg;

    localparam int MAX_FRAMES_DEF = 32768;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    // frame cursor width, covers (addr + len) / page for the smallest page
    localparam int CUR_W = 34;

    localparam int IN_W  = 120;
    localparam int OUT_W = 72;

    localparam logic [31:0] LOW_RESERVED = 32'h0010_0000;
    localparam logic [31:0] PROT_RESET   = 32'h0010_0000;

    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_PROT   = 1'b1;

    typedef enum logic [2:0] {
        OP_ALLOC_ONE     = 3'd0,
        OP_ALLOC_RUN     = 3'd1,
        OP_ALLOC_ALIGNED = 3'd2,
        OP_FREE_RUN      = 3'd3,
        OP_QUERY         = 3'd4,
        OP_RELEASE       = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FETCH,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        MD_SEARCH,
        MD_ACHECK,
        MD_MARK,
        MD_FREE,
        MD_QUERY
    } mode_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bpfa_ram.sv
`default_nettype none
module bpfa_ram
    import bpfa_pkg::*;
#(
    parameter int WIDTH = WORD_BITS_DEF,
    parameter int DEPTH = MAX_FRAMES_DEF / WORD_BITS_DEF
)(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/bpfa_div.sv
`default_nettype none
// Word and bit split of a frame number. The divisor is a power of two, so this is a
// registered shift and mask; done is registered from start and rises in the cycle after it.
module bpfa_div
    import bpfa_pkg::*;
#(
    parameter int DIVISOR = WORD_BITS_DEF,
    parameter int W       = CUR_W
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [W-1:0]                 din,
    output logic                         done,
    output logic [W-1:0]                 quo,
    output logic [$clog2(DIVISOR)-1:0]   rmd
);

    localparam int QW = $clog2(DIVISOR);

    logic          done_reg;
    logic [W-1:0]  quo_reg;
    logic [QW-1:0] rmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= din >> QW;
            rmd_reg <= din[QW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rmd  = rmd_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/bitmap_page_frame_allocator.sv
`default_nettype none
// Bitmap page frame allocator. One used bit per frame lives in a single-port-write RAM of
// WORD_BITS-wide words, worked on through a one-word cache; the request sequencer visits one
// frame per cycle while the frame's word is cached, and on a miss moves a word into the cache
// through a fetch and a wait state. Alloc one and alloc run scan to the end of the first
// fitting run and then mark it from its start; the aligned alloc checks each aligned candidate
// and then marks the run, free run and release clear frame by frame, and query reads a single
// bit. Free, query and release first split the frame number of their address into word and
// bit in the divider, and the aligned alloc splits its stride there. m_tvalid is registered
// from ST_FIN after the last step; one request is in flight at a time and s_tready stays low
// while a result waits. After reset and after every write of frames_in_use_range the RAM is
// filled with ones, one word per cycle, while no request is taken. Registers:
// 0x0 frames_in_use_range, 0x4 protected_end_address.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // operation[2:0], address[34:3], frame_count[50:35], alignment_bytes[82:51],
    // region_length[114:83], zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // ok[0], frame_address[32:1], is_allocated[33], in_range[34], used_total[50:35],
    // free_total[66:51], zero pad
    output logic [OUT_W-1:0] m_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PBL = $clog2(PAGE_BYTES);
    localparam int FW  = 32 - PBL;
    localparam int WC  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIW = (WC > 1) ? $clog2(WC) : 1;
    localparam int BIW = $clog2(WORD_BITS);

    // fields
    logic [2:0]  in_op;
    logic [31:0] in_addr;
    logic [15:0] in_cnt;
    logic [31:0] in_align;
    logic [31:0] in_len;

    assign in_op    = s_tdata[2:0];
    assign in_addr  = s_tdata[34:3];
    assign in_cnt   = s_tdata[50:35];
    assign in_align = s_tdata[82:51];
    assign in_len   = s_tdata[114:83];

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [CUR_W-1:0] cur_reg, cur_next;
    logic [WIW-1:0]   cw_reg, cw_next;
    logic [BIW-1:0]   cb_reg, cb_next;
    logic [CUR_W-1:0] rem_reg, rem_next;
    logic [15:0]      n_reg, n_next;
    logic [15:0]      run_reg, run_next;
    logic [CUR_W-1:0] s_reg, s_next;
    logic [WIW-1:0]   sw_reg, sw_next;
    logic [BIW-1:0]   sb_reg, sb_next;
    logic [CUR_W-1:0] cand_reg, cand_next;
    logic [WIW-1:0]   candw_reg, candw_next;
    logic [BIW-1:0]   candb_reg, candb_next;
    logic [CUR_W-1:0] step_reg, step_next;
    logic [WIW-1:0]   stepw_reg, stepw_next;
    logic [BIW-1:0]   stepb_reg, stepb_next;

    logic [WORD_BITS-1:0] cache_reg, cache_next;
    logic [WIW-1:0]       cidx_reg, cidx_next;
    logic                 cval_reg, cval_next;
    logic                 cdirty_reg, cdirty_next;
    logic [WIW-1:0]       clr_reg, clr_next;

    logic             ok_reg, ok_next;
    logic [CUR_W-1:0] start_reg, start_next;
    logic             isa_reg, isa_next;
    logic             inr_reg, inr_next;
    logic [15:0]      used_reg, used_next;
    logic [15:0]      frames_reg, frames_next;
    logic [31:0]      prot_reg, prot_next;
    logic             ovalid_reg, ovalid_next;
    logic [OUT_W-1:0] odata_reg, odata_next;

    // RAM and divider hookup
    logic                 ram_we;
    logic [WIW-1:0]       ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 div_start;
    logic [CUR_W-1:0]     div_in;
    logic                 div_done;
    logic [CUR_W-1:0]     div_quo;
    logic [BIW-1:0]       div_rmd;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WC)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cw_reg),
        .rdata (ram_rdata)
    );

    bpfa_div #(
        .DIVISOR (WORD_BITS),
        .W       (CUR_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .din   (div_in),
        .done  (div_done),
        .quo   (div_quo),
        .rmd   (div_rmd)
    );

    // derived values
    logic [CUR_W-1:0] tot;
    logic [32:0]      addr_up, addr_end, guard_up;
    logic [31:0]      guard;
    logic [CUR_W-1:0] rel_first, rel_last, guard_f, rel_st, rel_en, addr_f;
    logic [CUR_W-1:0] step_f;
    logic             align_bad;
    logic             hit;
    logic             cur_bit;
    logic [WIW-1:0]   cw_inc;
    logic [BIW-1:0]   cb_inc;
    logic [CUR_W-1:0] cand_add;
    logic [BIW:0]     candb_sum;
    logic             cfg_we;
    logic [15:0]      free_calc;

    assign tot = (CUR_W'(frames_reg) < CUR_W'(MAX_FRAMES)) ? CUR_W'(frames_reg)
                                                           : CUR_W'(MAX_FRAMES);
    assign addr_up   = {1'b0, in_addr} + 33'(PAGE_BYTES - 1);
    assign addr_end  = {1'b0, in_addr} + {1'b0, in_len};
    assign guard     = (prot_reg > LOW_RESERVED) ? prot_reg : LOW_RESERVED;
    assign guard_up  = {1'b0, guard} + 33'(PAGE_BYTES - 1);
    assign rel_first = CUR_W'(addr_up >> PBL);
    assign rel_last  = CUR_W'(addr_end >> PBL);
    assign guard_f   = CUR_W'(guard_up >> PBL);
    assign rel_st    = (rel_first > guard_f) ? rel_first : guard_f;
    assign rel_en    = (rel_last < tot) ? rel_last : tot;
    assign addr_f    = CUR_W'(in_addr >> PBL);
    assign step_f    = ((in_align >> PBL) == 32'd0) ? CUR_W'(1) : CUR_W'(in_align >> PBL);
    assign align_bad = (in_align == 32'd0) || ((in_align & (in_align - 32'd1)) != 32'd0);

    assign hit     = cval_reg && (cidx_reg == cw_reg);
    assign cur_bit = cache_reg[cb_reg];
    assign cw_inc  = (cb_reg == BIW'(WORD_BITS - 1)) ? cw_reg + 1'b1 : cw_reg;
    assign cb_inc  = (cb_reg == BIW'(WORD_BITS - 1)) ? '0 : cb_reg + 1'b1;

    assign cand_add  = cand_reg + step_reg;
    assign candb_sum = {1'b0, candb_reg} + {1'b0, stepb_reg};

    assign cfg_we    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_PROT) ? prot_reg : {16'd0, frames_reg};
    assign free_calc = (tot > CUR_W'(used_reg)) ? 16'(tot - CUR_W'(used_reg)) : 16'd0;

    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        cur_next    = cur_reg;
        cw_next     = cw_reg;
        cb_next     = cb_reg;
        rem_next    = rem_reg;
        n_next      = n_reg;
        run_next    = run_reg;
        s_next      = s_reg;
        sw_next     = sw_reg;
        sb_next     = sb_reg;
        cand_next   = cand_reg;
        candw_next  = candw_reg;
        candb_next  = candb_reg;
        step_next   = step_reg;
        stepw_next  = stepw_reg;
        stepb_next  = stepb_reg;
        cache_next  = cache_reg;
        cidx_next   = cidx_reg;
        cval_next   = cval_reg;
        cdirty_next = cdirty_reg;
        clr_next    = clr_reg;
        ok_next     = ok_reg;
        start_next  = start_reg;
        isa_next    = isa_reg;
        inr_next    = inr_reg;
        used_next   = used_reg;
        frames_next = frames_reg;
        prot_next   = prot_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        ram_we      = 1'b0;
        ram_waddr   = cidx_reg;
        ram_wdata   = cache_reg;
        ram_re      = 1'b0;
        div_start   = 1'b0;
        div_in      = addr_f;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
                cval_next = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == WIW'(WC - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    ok_next    = 1'b0;
                    isa_next   = 1'b0;
                    inr_next   = 1'b0;
                    start_next = '0;
                    run_next   = '0;
                    cur_next   = '0;
                    cw_next    = '0;
                    cb_next    = '0;
                    state_next = ST_FIN;
                    case (in_op)
                        OP_ALLOC_ONE:
                        begin
                            n_next     = 16'd1;
                            mode_next  = MD_SEARCH;
                            state_next = ST_RUN;
                        end
                        OP_ALLOC_RUN:
                        begin
                            n_next    = in_cnt;
                            mode_next = MD_SEARCH;
                            if (in_cnt != 16'd0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        OP_ALLOC_ALIGNED:
                        begin
                            n_next     = in_cnt;
                            rem_next   = CUR_W'(in_cnt);
                            mode_next  = MD_ACHECK;
                            cand_next  = '0;
                            candw_next = '0;
                            candb_next = '0;
                            step_next  = step_f;
                            if (in_cnt != 16'd0 && !align_bad && tot != '0
                                && CUR_W'(in_cnt) <= tot)
                            begin
                                div_in     = step_f;
                                div_start  = 1'b1;
                                state_next = ST_SETUP;
                            end
                        end
                        OP_FREE_RUN:
                        begin
                            rem_next  = CUR_W'(in_cnt);
                            cur_next  = addr_f;
                            mode_next = MD_FREE;
                            if (in_cnt != 16'd0)
                            begin
                                div_in     = addr_f;
                                div_start  = 1'b1;
                                state_next = ST_SETUP;
                            end
                        end
                        OP_QUERY:
                        begin
                            cur_next  = addr_f;
                            mode_next = MD_QUERY;
                            if (addr_f < tot)
                            begin
                                div_in     = addr_f;
                                div_start  = 1'b1;
                                state_next = ST_SETUP;
                            end
                            else
                            begin
                                isa_next = 1'b1;
                            end
                        end
                        OP_RELEASE:
                        begin
                            cur_next  = rel_st;
                            rem_next  = rel_en - rel_st;
                            mode_next = MD_FREE;
                            if (rel_st < rel_en)
                            begin
                                div_in     = rel_st;
                                div_start  = 1'b1;
                                state_next = ST_SETUP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_SETUP:
            begin
                if (div_done)
                begin
                    if (mode_reg == MD_ACHECK)
                    begin
                        stepw_next = WIW'(div_quo);
                        stepb_next = div_rmd;
                    end
                    else
                    begin
                        cw_next = WIW'(div_quo);
                        cb_next = div_rmd;
                    end
                    state_next = ST_RUN;
                end
            end

            ST_FETCH:
            begin
                // write back the old word while the new one is read
                ram_we      = cval_reg && cdirty_reg;
                ram_re      = 1'b1;
                cidx_next   = cw_reg;
                cval_next   = 1'b0;
                cdirty_next = 1'b0;
                state_next  = ST_WAIT;
            end

            ST_WAIT:
            begin
                cache_next = ram_rdata;
                cval_next  = 1'b1;
                state_next = ST_RUN;
            end

            ST_RUN:
            begin
                case (mode_reg)
                    MD_SEARCH:
                    begin
                        if (cur_reg >= tot)
                        begin
                            state_next = ST_FIN;
                        end
                        else if (!hit)
                        begin
                            state_next = ST_FETCH;
                        end
                        else if (!cur_bit)
                        begin
                            if (run_reg == 16'd0)
                            begin
                                s_next  = cur_reg;
                                sw_next = cw_reg;
                                sb_next = cb_reg;
                            end
                            if (run_reg + 16'd1 == n_reg)
                            begin
                                mode_next = MD_MARK;
                                rem_next  = CUR_W'(n_reg);
                                if (run_reg != 16'd0)
                                begin
                                    start_next = s_reg;
                                    cur_next   = s_reg;
                                    cw_next    = sw_reg;
                                    cb_next    = sb_reg;
                                end
                                else
                                begin
                                    start_next = cur_reg;
                                end
                            end
                            else
                            begin
                                run_next = run_reg + 16'd1;
                                cur_next = cur_reg + 1'b1;
                                cw_next  = cw_inc;
                                cb_next  = cb_inc;
                            end
                        end
                        else
                        begin
                            run_next = '0;
                            cur_next = cur_reg + 1'b1;
                            cw_next  = cw_inc;
                            cb_next  = cb_inc;
                        end
                    end

                    MD_ACHECK:
                    begin
                        if (!hit)
                        begin
                            state_next = ST_FETCH;
                        end
                        else if (cur_bit)
                        begin
                            // next aligned start
                            if (cand_add >= tot || cand_add + CUR_W'(n_reg) > tot)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                cand_next = cand_add;
                                cur_next  = cand_add;
                                rem_next  = CUR_W'(n_reg);
                                if (candb_sum >= (BIW + 1)'(WORD_BITS))
                                begin
                                    candb_next = BIW'(candb_sum - (BIW + 1)'(WORD_BITS));
                                    candw_next = candw_reg + stepw_reg + 1'b1;
                                end
                                else
                                begin
                                    candb_next = BIW'(candb_sum);
                                    candw_next = candw_reg + stepw_reg;
                                end
                                cw_next = (candb_sum >= (BIW + 1)'(WORD_BITS))
                                          ? candw_reg + stepw_reg + 1'b1
                                          : candw_reg + stepw_reg;
                                cb_next = (candb_sum >= (BIW + 1)'(WORD_BITS))
                                          ? BIW'(candb_sum - (BIW + 1)'(WORD_BITS))
                                          : BIW'(candb_sum);
                            end
                        end
                        else if (rem_reg == CUR_W'(1))
                        begin
                            mode_next  = MD_MARK;
                            rem_next   = CUR_W'(n_reg);
                            start_next = cand_reg;
                            cur_next   = cand_reg;
                            cw_next    = candw_reg;
                            cb_next    = candb_reg;
                        end
                        else
                        begin
                            rem_next = rem_reg - 1'b1;
                            cur_next = cur_reg + 1'b1;
                            cw_next  = cw_inc;
                            cb_next  = cb_inc;
                        end
                    end

                    MD_MARK:
                    begin
                        if (!hit)
                        begin
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            cache_next[cb_reg] = 1'b1;
                            cdirty_next        = 1'b1;
                            rem_next           = rem_reg - 1'b1;
                            cur_next           = cur_reg + 1'b1;
                            cw_next            = cw_inc;
                            cb_next            = cb_inc;
                            if (rem_reg == CUR_W'(1))
                            begin
                                used_next  = used_reg + n_reg;
                                ok_next    = 1'b1;
                                state_next = ST_FIN;
                            end
                        end
                    end

                    MD_FREE:
                    begin
                        if (rem_reg == '0)
                        begin
                            state_next = ST_FIN;
                        end
                        else if (cur_reg < tot && !hit)
                        begin
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            if (cur_reg < tot && cur_bit)
                            begin
                                cache_next[cb_reg] = 1'b0;
                                cdirty_next        = 1'b1;
                                if (used_reg != 16'd0)
                                begin
                                    used_next = used_reg - 16'd1;
                                end
                            end
                            rem_next = rem_reg - 1'b1;
                            // frame numbers wrap with the 32-bit address
                            if (&cur_reg[FW-1:0])
                            begin
                                cur_next = '0;
                                cw_next  = '0;
                                cb_next  = '0;
                            end
                            else
                            begin
                                cur_next = cur_reg + 1'b1;
                                cw_next  = cw_inc;
                                cb_next  = cb_inc;
                            end
                        end
                    end

                    MD_QUERY:
                    begin
                        if (!hit)
                        begin
                            state_next = ST_FETCH;
                        end
                        else
                        begin
                            isa_next   = cur_bit;
                            inr_next   = 1'b1;
                            state_next = ST_FIN;
                        end
                    end

                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end

            ST_FIN:
            begin
                ovalid_next = 1'b1;
                odata_next  = {5'd0, free_calc, used_reg, inr_reg, isa_reg,
                               ok_reg ? 32'(start_reg << PBL) : 32'd0, ok_reg};
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (paddr[2] == REG_FRAMES)
            begin
                frames_next = pwdata[15:0];
                used_next   = (CUR_W'(pwdata[15:0]) < CUR_W'(MAX_FRAMES))
                              ? pwdata[15:0] : 16'(MAX_FRAMES);
                clr_next    = '0;
                cval_next   = 1'b0;
                state_next  = ST_CLEAR;
            end
            else
            begin
                prot_next = pwdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            mode_reg   <= MD_SEARCH;
            clr_reg    <= '0;
            cval_reg   <= 1'b0;
            cdirty_reg <= 1'b0;
            used_reg   <= '0;
            frames_reg <= '0;
            prot_reg   <= PROT_RESET;
            ovalid_reg <= 1'b0;
            ok_reg     <= 1'b0;
            isa_reg    <= 1'b0;
            inr_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            clr_reg    <= clr_next;
            cval_reg   <= cval_next;
            cdirty_reg <= cdirty_next;
            used_reg   <= used_next;
            frames_reg <= frames_next;
            prot_reg   <= prot_next;
            ovalid_reg <= ovalid_next;
            ok_reg     <= ok_next;
            isa_reg    <= isa_next;
            inr_reg    <= inr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        cw_reg    <= cw_next;
        cb_reg    <= cb_next;
        rem_reg   <= rem_next;
        n_reg     <= n_next;
        run_reg   <= run_next;
        s_reg     <= s_next;
        sw_reg    <= sw_next;
        sb_reg    <= sb_next;
        cand_reg  <= cand_next;
        candw_reg <= candw_next;
        candb_reg <= candb_next;
        step_reg  <= step_next;
        stepw_reg <= stepw_next;
        stepb_reg <= stepb_next;
        cache_reg <= cache_next;
        cidx_reg  <= cidx_next;
        start_reg <= start_next;
        odata_reg <= odata_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/bpfa_chk.sv
`default_nettype none
`include "bitmap_page_frame_allocator_macros.svh"
module bpfa_chk
    import bpfa_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             pready
);

    // one request in flight: no new request while a result waits
    `BPFA_ASSERT_NOW(a_one_in_flight, m_tvalid, !s_tready, "request taken while result pending")

    // a result never appears in the cycle right after its request
    `BPFA_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !m_tvalid, "result too early")

    `BPFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `BPFA_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind bitmap_page_frame_allocator bpfa_chk u_bpfa_chk (.*);
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
module tb;
    import bpfa_pkg::*;

    localparam int FRAMES_MAX = MAX_FRAMES_DEF;
    localparam int PAGE       = PAGE_BYTES_DEF;

    typedef struct packed {
        logic        ok;
        logic [31:0] frame_address;
        logic        is_allocated;
        logic        in_range;
        logic [15:0] used_total;
        logic [15:0] free_total;
    } alloc_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // operation, address, frame_count, alignment_bytes, region_length, zero pad
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // ok, frame_address, is_allocated, in_range, used_total, free_total, zero pad
    logic [OUT_W-1:0]  m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // shadow allocator state
    bit          frame_used [FRAMES_MAX];
    int unsigned used_count;
    logic [15:0] frames_reg;
    logic [31:0] prot_end;

    alloc_result_t pending_results [$];
    int            errors = 0;
    int            hold_cycles = 0;

    bitmap_page_frame_allocator dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned managed_frames();
        return (frames_reg < FRAMES_MAX) ? frames_reg : FRAMES_MAX;
    endfunction

    function automatic void mark_all_used();
        foreach (frame_used[i]) frame_used[i] = 1'b1;
    endfunction

    function automatic void release_frame(longint unsigned f);
        if (f < managed_frames() && frame_used[f])
        begin
            frame_used[f] = 1'b0;
            if (used_count > 0) used_count--;
        end
    endfunction

    function automatic bit claim_run(longint unsigned start, int unsigned n);
        if (start + n > managed_frames()) return 1'b0;
        for (int unsigned j = 0; j < n; j++)
            if (frame_used[start + j]) return 1'b0;
        for (int unsigned j = 0; j < n; j++) frame_used[start + j] = 1'b1;
        used_count += n;
        return 1'b1;
    endfunction

    function automatic bit first_fit(int unsigned n, output int unsigned start);
        int unsigned run_len = 0;
        int unsigned run_start = 0;
        start = 0;
        for (int unsigned i = 0; i < managed_frames(); i++)
        begin
            if (!frame_used[i])
            begin
                if (run_len == 0) run_start = i;
                run_len++;
                if (run_len == n)
                begin
                    void'(claim_run(run_start, n));
                    start = run_start;
                    return 1'b1;
                end
            end
            else
                run_len = 0;
        end
        return 1'b0;
    endfunction

    function automatic bit aligned_fit(int unsigned n, logic [31:0] align,
                                       output int unsigned start);
        longint unsigned stride;
        start = 0;
        if (n == 0 || align == 0 || (align & (align - 1)) != 0) return 1'b0;
        stride = align / PAGE;
        if (stride == 0) stride = 1;
        for (longint unsigned i = 0; i < managed_frames(); i += stride)
            if (claim_run(i, n))
            begin
                start = 32'(i);
                return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic alloc_result_t predict_alloc(logic [2:0] op, logic [31:0] addr,
                                                    logic [15:0] cnt, logic [31:0] align,
                                                    logic [31:0] len);
        alloc_result_t r;
        int unsigned start = 0;
        longint unsigned f, first, last, guard;
        logic [31:0] a;
        r = '0;
        case (op)
            OP_ALLOC_ONE: r.ok = first_fit(1, start);
            OP_ALLOC_RUN: if (cnt != 0) r.ok = first_fit(cnt, start);
            OP_ALLOC_ALIGNED: r.ok = aligned_fit(cnt, align, start);
            OP_FREE_RUN:
                for (int unsigned i = 0; i < cnt; i++)
                begin
                    a = addr + i * PAGE;
                    release_frame(a / PAGE);
                end
            OP_QUERY:
            begin
                f = addr / PAGE;
                r.in_range = f < managed_frames();
                r.is_allocated = r.in_range ? frame_used[f] : 1'b1;
            end
            OP_RELEASE:
            begin
                first = (longint'(addr) + PAGE - 1) / PAGE;
                last = (longint'(addr) + longint'(len)) / PAGE;
                guard = (prot_end > LOW_RESERVED) ? prot_end : LOW_RESERVED;
                if (last > managed_frames()) last = managed_frames();
                for (f = first; f < last; f++)
                    if (f * PAGE >= guard) release_frame(f);
            end
            default: ;
        endcase
        if (r.ok) r.frame_address = start * PAGE;
        r.used_total = used_count[15:0];
        r.free_total = 16'((managed_frames() > used_count)
                           ? managed_frames() - used_count : 0);
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(negedge clk);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [2:0] op, logic [31:0] addr, logic [15:0] cnt,
                                logic [31:0] align, logic [31:0] len, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            idle_cycles(gap);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, len, align, cnt, addr, op};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(predict_alloc(op, addr, cnt, align, len));
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        idle_cycles(20);
    endtask

    task automatic write_reg(logic sel, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (sel == REG_FRAMES)
        begin
            frames_reg = value[15:0];
            mark_all_used();
            used_count = managed_frames();
        end
        else
            prot_end = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: random stalls plus a long hold-off when requested
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    idle_cycles(gap - 1);
                    @(negedge clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[34],
                   m_tdata[50:35], m_tdata[66:51]};
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                begin
                    $error("ok: expected %0d got %0d", want.ok, got.ok);
                    errors++;
                end
                if (got.frame_address !== want.frame_address)
                begin
                    $error("frame_address: expected %h got %h",
                           want.frame_address, got.frame_address);
                    errors++;
                end
                if (got.is_allocated !== want.is_allocated)
                begin
                    $error("is_allocated: expected %0d got %0d",
                           want.is_allocated, got.is_allocated);
                    errors++;
                end
                if (got.in_range !== want.in_range)
                begin
                    $error("in_range: expected %0d got %0d", want.in_range, got.in_range);
                    errors++;
                end
                if (got.used_total !== want.used_total)
                begin
                    $error("used_total: expected %0d got %0d",
                           want.used_total, got.used_total);
                    errors++;
                end
                if (got.free_total !== want.free_total)
                begin
                    $error("free_total: expected %0d got %0d",
                           want.free_total, got.free_total);
                    errors++;
                end
            end
        end
    end

    task automatic test_unconfigured();
        send_request(OP_ALLOC_ONE, 0, 0, 0, 0);
        send_request(OP_QUERY, 32'h0010_0000, 0, 0, 0);
        send_request(OP_RELEASE, 0, 0, 0, 32'h0100_0000);
        drain();
    endtask

    task automatic test_directed();
        write_reg(REG_FRAMES, 320);
        write_reg(REG_PROT, 0);
        send_request(OP_QUERY, 32'h0010_0000, 0, 0, 0);
        send_request(OP_RELEASE, 32'h000F_F000, 0, 0, 32'h0004_1000);
        send_request(OP_QUERY, 32'h0010_0FFF, 0, 0, 0);
        send_request(OP_ALLOC_ONE, 0, 0, 0, 0);
        send_request(OP_ALLOC_RUN, 0, 0, 0, 0);
        send_request(OP_ALLOC_RUN, 0, 1, 0, 0);
        send_request(OP_ALLOC_RUN, 0, 5, 0, 0);
        send_request(OP_ALLOC_RUN, 0, 16'hFFFF, 0, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 0, 32'h1000, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 2, 0, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 2, 3, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 2, 1, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 4, 32'h0001_0000, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 1, 32'h8000_0000, 0);
        send_request(OP_FREE_RUN, 32'h0010_0000, 2, 0, 0);
        send_request(OP_FREE_RUN, 32'h0010_0000, 2, 0, 0);
        // wraps from the top of the address space to frame 0
        send_request(OP_FREE_RUN, 32'hFFFF_F000, 3, 0, 0);
        send_request(OP_FREE_RUN, 32'h0010_5123, 16'hFFFF, 0, 0);
        send_request(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(3'd7, 0, 0, 0, 0);
        send_request(OP_RELEASE, 32'h0010_0001, 0, 0, 32'h3000);
        send_request(OP_RELEASE, 32'h0011_0000, 0, 0, 0);
        send_request(OP_RELEASE, 32'hFFFF_F000, 0, 0, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
        drain();
    endtask

    task automatic random_request(bit no_gap = 0);
        int roll;
        logic [31:0] addr, align, len;
        logic [15:0] cnt;
        logic [2:0]  op;
        roll = $urandom_range(0, 99);
        addr = $urandom_range(0, managed_frames() + 8) * PAGE;
        if ($urandom_range(0, 3) == 0) addr += $urandom_range(0, PAGE - 1);
        if ($urandom_range(0, 9) == 0) addr = $urandom();
        cnt = 16'($urandom_range(0, 6));
        align = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 7) == 0) align = $urandom();
        len = $urandom_range(0, 32'h0004_0000);
        if (roll < 15) op = OP_ALLOC_ONE;
        else if (roll < 30)
        begin
            op = OP_ALLOC_RUN;
            if ($urandom_range(0, 19) == 0) cnt = 16'($urandom());
        end
        else if (roll < 42)
        begin
            op = OP_ALLOC_ALIGNED;
            cnt = 16'($urandom_range(0, 4));
        end
        else if (roll < 67)
        begin
            op = OP_FREE_RUN;
            cnt = 16'($urandom_range(0, 8));
        end
        else if (roll < 82) op = OP_QUERY;
        else if (roll < 97)
        begin
            op = OP_RELEASE;
            if ($urandom_range(0, 3) != 0)
                addr = $urandom_range(32'h000F_0000, managed_frames() * PAGE + PAGE)
                       + $urandom_range(0, 1);
        end
        else op = 3'($urandom_range(6, 7));
        send_request(op, addr, cnt, align, len, no_gap);
    endtask

    task automatic test_random_settings();
        logic [31:0] prot_values [6];
        prot_values = '{32'h0, 32'h0010_0000, 32'h0012_3456, 32'h0013_0000,
                        32'hFFFF_FFFF, 32'h0011_0000};
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_FRAMES, (phase == 4) ? 256 : $urandom_range(257, 400));
            write_reg(REG_PROT, prot_values[phase]);
            send_request(OP_RELEASE, 32'h0010_0000, 0, 0, 32'h0010_0000);
            for (int n = 0; n < 180; n++) random_request();
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_FRAMES, 300);
        send_request(OP_RELEASE, 0, 0, 0, 32'h0020_0000);
        drain();
        hold_cycles = 400;
        for (int n = 0; n < 12; n++) random_request(1);
        drain();
    endtask

    task automatic test_full_size();
        write_reg(REG_FRAMES, 32'hFFFF);
        write_reg(REG_PROT, 32'h0080_0000);
        send_request(OP_RELEASE, 32'h0010_0000, 0, 0, 32'h0100_0000);
        send_request(OP_ALLOC_ONE, 0, 0, 0, 0);
        send_request(OP_ALLOC_RUN, 0, 100, 0, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 4, 32'h0010_0000, 0);
        send_request(OP_QUERY, 32'h07FF_F000, 0, 0, 0);
        send_request(OP_QUERY, 32'h0800_0000, 0, 0, 0);
        send_request(OP_FREE_RUN, 32'h0080_0000, 16, 0, 0);
        send_request(OP_FREE_RUN, 32'h0000_0000, 16'h8000, 0, 0);
        send_request(OP_ALLOC_RUN, 0, 4000, 0, 0);
        send_request(OP_RELEASE, 32'h0000_0000, 0, 0, 32'h0800_0000);
        send_request(OP_ALLOC_RUN, 0, 16'h8000, 0, 0);
        drain();
        write_reg(REG_FRAMES, 0);
        send_request(OP_ALLOC_ALIGNED, 0, 1, 1, 0);
        drain();
    endtask

    initial
    begin
        frames_reg = '0;
        prot_end = PROT_RESET;
        used_count = 0;
        mark_all_used();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_unconfigured();
        test_directed();
        test_backpressure();
        test_random_settings();
        test_full_size();
        if (errors == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
